FILE: hw/rtl/triangle_face_normal_unit_assert.svh
// assertion macros shared by the triangle face normal unit
`ifndef TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH

// property holds at every edge outside reset
`define TFN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TFN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/tfn_pkg.sv
// ---------------------------------------------------------------------------
// tfn_pkg
// shared types, widths and command codes of the triangle face normal unit
// ---------------------------------------------------------------------------
package tfn_pkg;

  localparam int VERTEX_DEPTH = 16384;
  localparam int SLOT_W = 14;
  localparam int ADDR_W = $clog2(VERTEX_DEPTH);
  localparam int POS_W = 20;
  localparam int NRM_W = 16;
  localparam int PROD_W = 43;
  localparam int MAG_W = 31;
  localparam int SUM_W = 63;
  localparam int ROOT_W = 32;
  localparam int NUM_W = 46;
  localparam int QUO_W = 15;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_NORMAL = 1'b1;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_WRITE,
    CMD_READ_A,
    CMD_READ_B,
    CMD_READ_C,
    CMD_EDGES,
    CMD_CROSS,
    CMD_NEG,
    CMD_ALIGN,
    CMD_SQUARE,
    CMD_SUM,
    CMD_ROOT,
    CMD_DIV_INIT,
    CMD_DIV,
    CMD_OUT
  } tfn_cmd_e;

  typedef struct packed {
    tfn_cmd_e cmd;
    logic [1:0] comp;
  } tfn_ctl_t;

  typedef struct packed {
    logic degen;
    logic aligned;
    logic step_done;
  } tfn_stat_t;

endpackage

FILE: hw/rtl/tfn_ctrl.sv
// ---------------------------------------------------------------------------
// tfn_ctrl
// sequencer that walks the datapath through one item
// ---------------------------------------------------------------------------
module tfn_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic action,
  input  tfn_pkg::tfn_stat_t stat,
  output tfn_pkg::tfn_ctl_t ctl,
  output logic busy
);
  import tfn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_RC, S_EDGE, S_CROSS, S_NEG, S_ALIGN,
    S_SQ, S_SUM, S_ROOT, S_DINIT, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [1:0] comp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      comp <= 2'd0;
      busy <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && action == ACTION_NORMAL) begin
            state <= S_RA;
            busy <= 1'b1;
          end
        end
        S_RA: state <= S_RB;
        S_RB: state <= S_RC;
        S_RC: state <= S_EDGE;
        S_EDGE: state <= S_CROSS;
        S_CROSS: state <= S_NEG;
        S_NEG: begin
          if (stat.degen) state <= S_OUT;
          else state <= S_ALIGN;
        end
        S_ALIGN: if (stat.aligned) state <= S_SQ;
        S_SQ: state <= S_SUM;
        S_SUM: state <= S_ROOT;
        S_ROOT: if (stat.step_done) begin
          state <= S_DINIT;
          comp <= 2'd0;
        end
        S_DINIT: state <= S_DIV;
        S_DIV: if (stat.step_done) begin
          if (comp == 2'd2) state <= S_OUT;
          else begin
            comp <= comp + 2'd1;
            state <= S_DINIT;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
          busy <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl.comp = comp;
    case (state)
      S_IDLE: ctl.cmd = (start && action == ACTION_WRITE) ? CMD_WRITE :
                        (start ? CMD_READ_A : CMD_IDLE);
      S_RA: ctl.cmd = CMD_READ_B;
      S_RB: ctl.cmd = CMD_READ_C;
      S_RC: ctl.cmd = CMD_IDLE;
      S_EDGE: ctl.cmd = CMD_EDGES;
      S_CROSS: ctl.cmd = CMD_CROSS;
      S_NEG: ctl.cmd = CMD_NEG;
      S_ALIGN: ctl.cmd = CMD_ALIGN;
      S_SQ: ctl.cmd = CMD_SQUARE;
      S_SUM: ctl.cmd = CMD_SUM;
      S_ROOT: ctl.cmd = CMD_ROOT;
      S_DINIT: ctl.cmd = CMD_DIV_INIT;
      S_DIV: ctl.cmd = CMD_DIV;
      S_OUT: ctl.cmd = CMD_OUT;
      default: ctl.cmd = CMD_IDLE;
    endcase
  end

  `include "triangle_face_normal_unit_assert.svh"
  `TFN_ASSERT_NEXT(a_out_frees, state == S_OUT, !busy, "busy after output")
  `TFN_ASSERT(a_idle_free, (state == S_IDLE) == !busy, "busy mismatch")
  `TFN_ASSERT(a_comp_rng, comp != 2'd3, "component index out of range")
endmodule

FILE: hw/rtl/tfn_datapath.sv
// ---------------------------------------------------------------------------
// tfn_datapath
// vertex store, cross product, alignment, square root and divider
// ---------------------------------------------------------------------------
module tfn_datapath (
  input  logic clk,
  input  logic rst,
  input  tfn_pkg::tfn_ctl_t ctl,
  input  logic [tfn_pkg::SLOT_W-1:0] vertex_slot,
  input  logic signed [tfn_pkg::POS_W-1:0] pos_x,
  input  logic signed [tfn_pkg::POS_W-1:0] pos_y,
  input  logic signed [tfn_pkg::POS_W-1:0] pos_z,
  input  logic [tfn_pkg::SLOT_W-1:0] corner_a,
  input  logic [tfn_pkg::SLOT_W-1:0] corner_b,
  input  logic [tfn_pkg::SLOT_W-1:0] corner_c,
  output tfn_pkg::tfn_stat_t stat,
  output logic done,
  output logic signed [tfn_pkg::NRM_W-1:0] normal_x,
  output logic signed [tfn_pkg::NRM_W-1:0] normal_y,
  output logic signed [tfn_pkg::NRM_W-1:0] normal_z,
  output logic degenerate
);
  import tfn_pkg::*;

  logic [3*POS_W-1:0] mem [VERTEX_DEPTH];
  logic [3*POS_W-1:0] rd;
  logic [SLOT_W-1:0] idx_b, idx_c;
  logic signed [POS_W-1:0] pa [3];
  logic signed [POS_W-1:0] pb [3];
  logic signed [POS_W:0] u [3];
  logic signed [POS_W:0] v [3];
  logic signed [PROD_W-1:0] n [3];
  logic [PROD_W-1:0] mag [3];
  logic [2:0] neg;
  logic [SUM_W-1:0] sq [3];
  logic [ROOT_W-1:0] root;
  logic [5:0] cnt;
  logic [NUM_W-1:0] num;
  logic [QUO_W-1:0] quo [3];
  logic [PROD_W-1:0] maxm;
  logic [ROOT_W:0] drem;
  logic [ROOT_W-1:0] part_hi;
  logic [ROOT_W+1:0] sr_rem2;
  logic [ROOT_W+1:0] sr_try;

  // vertex store, one read port, registered data
  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_WRITE) begin
      mem[vertex_slot[ADDR_W-1:0]] <= {pos_z, pos_y, pos_x};
    end
    case (ctl.cmd)
      CMD_READ_A: rd <= mem[corner_a[ADDR_W-1:0]];
      CMD_READ_B: rd <= mem[idx_b[ADDR_W-1:0]];
      CMD_READ_C: rd <= mem[idx_c[ADDR_W-1:0]];
      default: rd <= rd;
    endcase
  end

  always_comb begin
    maxm = mag[0];
    if (mag[1] > maxm) maxm = mag[1];
    if (mag[2] > maxm) maxm = mag[2];
  end

  assign stat.degen = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
  assign stat.aligned = (maxm[PROD_W-1:MAG_W-1] == '0) && maxm[MAG_W-2];
  assign stat.step_done = (cnt == '0);

  // restoring square root, one result bit per step
  // the sum stays below 2^62, so 31 bit pairs cover it
  always_comb begin
    sr_rem2 = {part_hi, sq[0][SUM_W-2 -: 2]};
    sr_try = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    case (ctl.cmd)
      CMD_READ_A: begin
        idx_b <= corner_b;
        idx_c <= corner_c;
      end
      CMD_READ_B: begin
        pa[0] <= rd[POS_W-1:0];
        pa[1] <= rd[2*POS_W-1:POS_W];
        pa[2] <= rd[3*POS_W-1:2*POS_W];
      end
      CMD_READ_C: begin
        pb[0] <= rd[POS_W-1:0];
        pb[1] <= rd[2*POS_W-1:POS_W];
        pb[2] <= rd[3*POS_W-1:2*POS_W];
      end
      CMD_EDGES: begin
        for (int i = 0; i < 3; i++) begin
          u[i] <= (POS_W+1)'(pb[i]) - (POS_W+1)'(pa[i]);
          v[i] <= (POS_W+1)'($signed(rd[i*POS_W +: POS_W])) - (POS_W+1)'(pa[i]);
        end
      end
      CMD_CROSS: begin
        n[0] <= PROD_W'(u[2]) * PROD_W'(v[1]) - PROD_W'(u[1]) * PROD_W'(v[2]);
        n[1] <= PROD_W'(u[0]) * PROD_W'(v[2]) - PROD_W'(u[2]) * PROD_W'(v[0]);
        n[2] <= PROD_W'(u[1]) * PROD_W'(v[0]) - PROD_W'(u[0]) * PROD_W'(v[1]);
      end
      CMD_NEG: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= n[i][PROD_W-1];
          mag[i] <= n[i][PROD_W-1] ? PROD_W'(-n[i]) : n[i];
        end
      end
      CMD_ALIGN: begin
        // one bit a cycle toward [2^29, 2^30)
        if (maxm[PROD_W-1:MAG_W-1] != '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!maxm[MAG_W-2]) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      CMD_SQUARE: begin
        for (int i = 0; i < 3; i++)
          sq[i] <= SUM_W'(mag[i][MAG_W-2:0]) * SUM_W'(mag[i][MAG_W-2:0]);
      end
      CMD_SUM: begin
        sq[0] <= sq[0] + sq[1] + sq[2];
        part_hi <= '0;
        root <= '0;
        cnt <= 6'd31;
      end
      CMD_ROOT: begin
        // digit-by-digit root, one result bit per cycle
        if (cnt != '0) begin
          if (sr_rem2 >= sr_try) begin
            part_hi <= ROOT_W'(sr_rem2 - sr_try);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            part_hi <= sr_rem2[ROOT_W-1:0];
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          sq[0] <= {sq[0][SUM_W-3:0], 2'b00};
          cnt <= cnt - 6'd1;
        end
      end
      CMD_DIV_INIT: begin
        num <= (NUM_W'(mag[ctl.comp][MAG_W-2:0]) << 14) + NUM_W'(root >> 1);
        drem <= '0;
        cnt <= 6'(NUM_W);
      end
      CMD_DIV: begin
        // restoring division, one quotient bit per cycle
        if (cnt != '0) begin
          if ({drem[ROOT_W-1:0], num[NUM_W-1]} >= {1'b0, root}) begin
            drem <= {drem[ROOT_W-1:0], num[NUM_W-1]} - {1'b0, root};
            num <= {num[NUM_W-2:0], 1'b1};
          end else begin
            drem <= {drem[ROOT_W-1:0], num[NUM_W-1]};
            num <= {num[NUM_W-2:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
        end else begin
          quo[ctl.comp] <= num[QUO_W-1:0];
        end
      end
      CMD_OUT: begin
        done <= 1'b1;
        degenerate <= stat.degen;
        normal_x <= stat.degen ? '0 : (neg[0] ? -NRM_W'(quo[0]) : NRM_W'(quo[0]));
        normal_y <= stat.degen ? '0 : (neg[1] ? -NRM_W'(quo[1]) : NRM_W'(quo[1]));
        normal_z <= stat.degen ? '0 : (neg[2] ? -NRM_W'(quo[2]) : NRM_W'(quo[2]));
      end
      default: begin
      end
    endcase
  end

  `include "triangle_face_normal_unit_assert.svh"
  `TFN_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `TFN_ASSERT_NEXT(a_done_cmd, ctl.cmd == CMD_OUT, done, "no strobe after output")
  `TFN_ASSERT(a_deg_zero, !(done && degenerate) || (normal_x == '0 && normal_y == '0
    && normal_z == '0), "degenerate normal not zero")
endmodule

FILE: hw/rtl/triangle_face_normal_unit.sv
// ---------------------------------------------------------------------------
// triangle_face_normal_unit
// unit face normal of a triangle from a vertex store, signed q1.14 out
// ---------------------------------------------------------------------------
// a vertex write gives no result word and busy stays low
// a triangle's strobe follows three store reads, edges, cross product, alignment,
// square root and three divisions; a degenerate triangle skips alignment onward
// busy drops with the strobe; a new triangle is taken only once busy is low
// the result word shows on the strobe for one cycle; receiver cannot stall
// synchronous reset idles the sequencer; the vertex store is undefined until written
module triangle_face_normal_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic action,
  input  logic [tfn_pkg::SLOT_W-1:0] vertex_slot,
  input  logic signed [tfn_pkg::POS_W-1:0] pos_x,
  input  logic signed [tfn_pkg::POS_W-1:0] pos_y,
  input  logic signed [tfn_pkg::POS_W-1:0] pos_z,
  input  logic [tfn_pkg::SLOT_W-1:0] corner_a,
  input  logic [tfn_pkg::SLOT_W-1:0] corner_b,
  input  logic [tfn_pkg::SLOT_W-1:0] corner_c,
  output logic strobe,
  output logic signed [tfn_pkg::NRM_W-1:0] normal_x,
  output logic signed [tfn_pkg::NRM_W-1:0] normal_y,
  output logic signed [tfn_pkg::NRM_W-1:0] normal_z,
  output logic degenerate
);
  import tfn_pkg::*;

  tfn_ctl_t ctl;
  tfn_stat_t stat;
  logic done;

  // sequencer: one item at a time
  tfn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .stat(stat), .ctl(ctl), .busy(busy)
  );

  // datapath with the vertex store and arithmetic units
  tfn_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .vertex_slot(vertex_slot),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .stat(stat), .done(done),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate)
  );

  // strobe is cleared during reset
  assign strobe = done && !rst;
endmodule
